/* rtl/drp_pkg.sv */
package drp_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [ADDR_W-1:0] MAX_CNT = ADDR_W'(BUFFER_DEPTH - 1);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_PAYLOAD = 3'd1;
    localparam logic [2:0] PH_HIGH    = 3'd2;
    localparam logic [2:0] PH_LOW     = 3'd3;
    localparam logic [2:0] PH_READ    = 3'd4;

    typedef logic [ADDR_W-1:0] t_addr;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        case (c) inside
            [8'h30:8'h39]: v = c - 8'h30;
            [8'h61:8'h66]: v = c - 8'h61 + 8'd10;
            [8'h41:8'h46]: v = c - 8'h41 + 8'd10;
            default:       v = 8'hff;
        endcase
        return v;
    endfunction

endpackage

/* rtl/debug_packet_receiver.sv */
// one received byte accepted per cycle while a packet is being framed, unless stalled
// results are read from the store into the output register; empty packets skip the store
// unless stalled, readout streams one byte per cycle via the single read port of the store
// input is stalled during readout, and on the final check digit while a result still waits
// synchronous active-low reset clears control state; the payload store is not cleared
module debug_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_last_of_packet,
    output logic       o_empty_packet,
    output logic [5:0] o_packet_length
);

    logic [2:0]     r_phase, n_phase;
    logic [7:0]     r_sum, n_sum;
    logic [7:0]     r_check, n_check;
    drp_pkg::t_addr r_count, n_count;
    drp_pkg::t_addr r_issued, n_issued;
    drp_pkg::t_addr r_ld_idx, n_ld_idx;
    logic           r_rd_pend, n_rd_pend;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       r_out_empty, n_out_empty;
    logic [5:0] r_out_len, n_out_len;

    logic       in_acc;
    logic       out_take;
    logic       ld;
    logic       ld_last;
    logic       issue;
    logic       wr_en;
    logic [7:0] rd_data;
    logic [7:0] digit;
    logic [7:0] check_full;

    assign o_stall  = (r_phase == drp_pkg::PH_READ) ||
                      ((r_phase == drp_pkg::PH_LOW) && r_out_valid);
    assign in_acc   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    assign ld      = r_rd_pend && (!r_out_valid || !i_stall);
    assign ld_last = (r_ld_idx == (r_count - drp_pkg::ADDR_W'(1)));
    assign issue   = (r_phase == drp_pkg::PH_READ) && (r_issued < r_count) &&
                     (!r_rd_pend || ld);

    assign wr_en = in_acc && (r_phase == drp_pkg::PH_PAYLOAD) &&
                   (i_rx_byte != drp_pkg::CH_HASH) && (r_count < drp_pkg::MAX_CNT);

    assign digit      = drp_pkg::hex_value(i_rx_byte);
    assign check_full = r_check + digit;

    drp_ram #(
        .WIDTH (8),
        .DEPTH (drp_pkg::BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (r_issued),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_check     = r_check;
        n_count     = r_count;
        n_issued    = r_issued;
        n_ld_idx    = r_ld_idx;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_len   = r_out_len;

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_phase)
            drp_pkg::PH_IDLE: begin
                if (in_acc && (i_rx_byte == drp_pkg::CH_START)) begin
                    n_phase = drp_pkg::PH_PAYLOAD;
                    n_sum   = 8'd0;
                    n_check = 8'hff;
                    n_count = '0;
                end
            end
            drp_pkg::PH_PAYLOAD: begin
                if (in_acc) begin
                    if (i_rx_byte == drp_pkg::CH_HASH) begin
                        n_phase = drp_pkg::PH_HIGH;
                    end else if (r_count < drp_pkg::MAX_CNT) begin
                        n_sum   = r_sum + i_rx_byte;
                        n_count = r_count + drp_pkg::ADDR_W'(1);
                    end else begin
                        n_phase = drp_pkg::PH_IDLE;
                    end
                end
            end
            drp_pkg::PH_HIGH: begin
                if (in_acc) begin
                    n_check = {digit[3:0], 4'h0};
                    n_phase = drp_pkg::PH_LOW;
                end
            end
            drp_pkg::PH_LOW: begin
                if (in_acc) begin
                    n_check = check_full;
                    n_phase = drp_pkg::PH_IDLE;
                    if (check_full == r_sum) begin
                        if (r_count == '0) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = 8'd0;
                            n_out_last  = 1'b1;
                            n_out_empty = 1'b1;
                            n_out_len   = 6'd0;
                        end else begin
                            n_phase   = drp_pkg::PH_READ;
                            n_issued  = '0;
                            n_ld_idx  = '0;
                            n_rd_pend = 1'b0;
                        end
                    end
                end
            end
            drp_pkg::PH_READ: begin
                if (issue) begin
                    n_issued  = r_issued + drp_pkg::ADDR_W'(1);
                    n_rd_pend = 1'b1;
                end else if (ld) begin
                    n_rd_pend = 1'b0;
                end
                if (ld) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = rd_data;
                    n_out_last  = ld_last;
                    n_out_empty = 1'b0;
                    n_out_len   = 6'(r_count);
                    n_ld_idx    = r_ld_idx + drp_pkg::ADDR_W'(1);
                    if (ld_last) begin
                        n_phase = drp_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = drp_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= drp_pkg::PH_IDLE;
            r_sum       <= 8'd0;
            r_check     <= 8'd0;
            r_count     <= '0;
            r_issued    <= '0;
            r_ld_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_check     <= n_check;
            r_count     <= n_count;
            r_issued    <= n_issued;
            r_ld_idx    <= n_ld_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_len   <= n_out_len;
    end

    assign o_valid          = r_out_valid;
    assign o_payload_byte   = r_out_byte;
    assign o_last_of_packet = r_out_last;
    assign o_empty_packet   = r_out_empty;
    assign o_packet_length  = r_out_len;

    a_pend_only_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_phase == drp_pkg::PH_READ))
        else $error("read pending outside readout");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == drp_pkg::PH_LOW && in_acc) |-> !r_out_valid)
        else $error("final check digit taken while a result still waits");

    a_issue_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == drp_pkg::PH_READ) |-> (r_issued <= r_count))
        else $error("more reads issued than bytes stored");

    a_last_ends_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == drp_pkg::PH_READ && ld && ld_last) |=>
            (r_phase == drp_pkg::PH_IDLE && r_out_valid && r_out_last))
        else $error("readout did not close on the final byte");

endmodule

/* rtl/drp_ram.sv */
module drp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
